### sv/ccp_pkg.sv
// ----------------------------------------------------------------------------
// ccp_pkg: shared types and constants of the constant pool parser
// Tag codes, entry kinds, parse phases, the result record and the tag decoder.
// ----------------------------------------------------------------------------
package ccp_pkg;

  // Tag byte values defined by the class file format
  localparam logic [7:0] TAG_UTF8        = 8'd1;
  localparam logic [7:0] TAG_INTEGER     = 8'd3;
  localparam logic [7:0] TAG_FLOAT       = 8'd4;
  localparam logic [7:0] TAG_LONG        = 8'd5;
  localparam logic [7:0] TAG_DOUBLE      = 8'd6;
  localparam logic [7:0] TAG_CLASS       = 8'd7;
  localparam logic [7:0] TAG_STRING      = 8'd8;
  localparam logic [7:0] TAG_FIELDREF    = 8'd9;
  localparam logic [7:0] TAG_METHODREF   = 8'd10;
  localparam logic [7:0] TAG_IFMETHODREF = 8'd11;
  localparam logic [7:0] TAG_NAMETYPE    = 8'd12;
  localparam logic [7:0] TAG_HANDLE      = 8'd15;
  localparam logic [7:0] TAG_MTYPE       = 8'd16;
  localparam logic [7:0] TAG_INDY        = 8'd18;

  // Entry kind codes carried on the result
  localparam logic [3:0] KIND_UTF8        = 4'd0;
  localparam logic [3:0] KIND_INT         = 4'd1;
  localparam logic [3:0] KIND_FLOAT       = 4'd2;
  localparam logic [3:0] KIND_LONG        = 4'd3;
  localparam logic [3:0] KIND_DOUBLE      = 4'd4;
  localparam logic [3:0] KIND_CLASS       = 4'd5;
  localparam logic [3:0] KIND_STRING      = 4'd6;
  localparam logic [3:0] KIND_FIELDREF    = 4'd7;
  localparam logic [3:0] KIND_METHODREF   = 4'd8;
  localparam logic [3:0] KIND_IFMETHODREF = 4'd9;
  localparam logic [3:0] KIND_NAMETYPE    = 4'd10;
  localparam logic [3:0] KIND_HANDLE      = 4'd11;
  localparam logic [3:0] KIND_MTYPE       = 4'd12;
  localparam logic [3:0] KIND_INDY        = 4'd13;
  localparam logic [3:0] KIND_UNKNOWN     = 4'd14;

  // Parse phases, one-hot
  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_TAG   = 6'b000010,
    PH_FIXED = 6'b000100,
    PH_ULEN  = 6'b001000,
    PH_UTEXT = 6'b010000,
    PH_DONE  = 6'b100000
  } phase_t;

  // One result record
  typedef struct packed {
    logic [15:0] entry_index;
    logic [3:0]  entry_kind;
    logic [63:0] value_a;
    logic [15:0] value_b;
    logic [7:0]  text_byte;
    logic        is_text_byte;
    logic        is_last_entry;
  } result_t;

  // Decoded tag: kind and number of payload bytes that follow
  typedef struct packed {
    logic [3:0] kind;
    logic [3:0] len;
  } tag_info_t;

  function automatic tag_info_t decode_tag(input logic [7:0] tag);
    tag_info_t info;
    case (tag)
      TAG_UTF8:        info = '{kind: KIND_UTF8,        len: 4'd2};
      TAG_INTEGER:     info = '{kind: KIND_INT,         len: 4'd4};
      TAG_FLOAT:       info = '{kind: KIND_FLOAT,       len: 4'd4};
      TAG_LONG:        info = '{kind: KIND_LONG,        len: 4'd8};
      TAG_DOUBLE:      info = '{kind: KIND_DOUBLE,      len: 4'd8};
      TAG_CLASS:       info = '{kind: KIND_CLASS,       len: 4'd2};
      TAG_STRING:      info = '{kind: KIND_STRING,      len: 4'd2};
      TAG_FIELDREF:    info = '{kind: KIND_FIELDREF,    len: 4'd4};
      TAG_METHODREF:   info = '{kind: KIND_METHODREF,   len: 4'd4};
      TAG_IFMETHODREF: info = '{kind: KIND_IFMETHODREF, len: 4'd4};
      TAG_NAMETYPE:    info = '{kind: KIND_NAMETYPE,    len: 4'd4};
      TAG_HANDLE:      info = '{kind: KIND_HANDLE,      len: 4'd3};
      TAG_MTYPE:       info = '{kind: KIND_MTYPE,       len: 4'd2};
      TAG_INDY:        info = '{kind: KIND_INDY,        len: 4'd4};
      default:         info = '{kind: KIND_UNKNOWN,     len: 4'd0};
    endcase
    return info;
  endfunction

endpackage

### sv/ccp_parser.sv
// ----------------------------------------------------------------------------
// ccp_parser: constant pool parse state and per-byte step logic
// Holds the running parse state and works out, for each accepted byte, the
// next state and the result record that the byte completes, if any.
// ----------------------------------------------------------------------------
module ccp_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data,
  input  logic             step,
  input  logic [7:0]       byte_value,
  input  logic             start_of_pool,
  output logic             res_valid,
  output ccp_pkg::result_t res
);

  // Parse state registers
  logic [15:0]      pool_count;
  ccp_pkg::phase_t  phase;
  logic [15:0]      cur_index;
  logic [3:0]       cur_kind;
  logic [15:0]      bytes_left;
  logic [63:0]      acc;
  logic [15:0]      len_hold;

  ccp_pkg::phase_t  phase_next;
  logic [15:0]      cur_index_next;
  logic [3:0]       cur_kind_next;
  logic [15:0]      bytes_left_next;
  logic [63:0]      acc_next;
  logic [15:0]      len_hold_next;

  // State as seen after a possible restart
  ccp_pkg::phase_t   e_phase;
  logic [15:0]       e_index;
  logic [3:0]        e_kind;
  logic [15:0]       e_left;
  logic [63:0]       e_acc;
  logic [15:0]       e_hold;
  logic [63:0]       acc_sh;
  logic [15:0]       left_dec;
  logic [16:0]       sum1;
  logic [16:0]       sum2;
  logic              last1;
  logic              last2;
  ccp_pkg::tag_info_t tinfo;

  // Restart view of the state
  always_comb begin
    if (start_of_pool) begin
      e_index = 16'd1;
      e_kind  = ccp_pkg::KIND_UTF8;
      e_left  = '0;
      e_acc   = '0;
      e_hold  = '0;
      e_phase = (pool_count <= 16'd1) ? ccp_pkg::PH_DONE : ccp_pkg::PH_TAG;
    end else begin
      e_index = cur_index;
      e_kind  = cur_kind;
      e_left  = bytes_left;
      e_acc   = acc;
      e_hold  = len_hold;
      e_phase = phase;
    end
  end

  // Shared helpers: shift-accumulate, countdown and the two index advances
  assign acc_sh   = {e_acc[55:0], byte_value};
  assign left_dec = (e_left != 16'd0) ? e_left - 16'd1 : e_left;
  assign sum1     = {1'b0, e_index} + 17'd1;
  assign sum2     = {1'b0, e_index} + 17'd2;
  assign last1    = sum1 >= {1'b0, pool_count};
  assign last2    = sum2 >= {1'b0, pool_count};
  assign tinfo    = ccp_pkg::decode_tag(byte_value);

  // Per-byte step
  always_comb begin
    phase_next      = e_phase;
    cur_index_next  = e_index;
    cur_kind_next   = e_kind;
    bytes_left_next = e_left;
    acc_next        = e_acc;
    len_hold_next   = e_hold;
    res_valid       = 1'b0;
    res             = '0;
    res.entry_index = e_index;

    case (e_phase)
      ccp_pkg::PH_TAG: begin
        acc_next = '0;
        if (tinfo.kind == ccp_pkg::KIND_UNKNOWN) begin
          // A tag without a known layout is a one-byte entry
          res_valid         = 1'b1;
          res.entry_kind    = ccp_pkg::KIND_UNKNOWN;
          res.value_a       = {56'd0, byte_value};
          res.is_last_entry = last1;
          cur_index_next    = sum1[15:0];
          phase_next        = last1 ? ccp_pkg::PH_DONE : ccp_pkg::PH_TAG;
          bytes_left_next   = '0;
        end else begin
          cur_kind_next   = tinfo.kind;
          bytes_left_next = {12'd0, tinfo.len};
          phase_next      = (tinfo.kind == ccp_pkg::KIND_UTF8) ?
                            ccp_pkg::PH_ULEN : ccp_pkg::PH_FIXED;
        end
      end

      ccp_pkg::PH_FIXED: begin
        acc_next        = acc_sh;
        bytes_left_next = left_dec;
        if (left_dec == 16'd0) begin
          res_valid      = 1'b1;
          res.entry_kind = e_kind;
          case (e_kind)
            ccp_pkg::KIND_FIELDREF, ccp_pkg::KIND_METHODREF,
            ccp_pkg::KIND_IFMETHODREF, ccp_pkg::KIND_NAMETYPE,
            ccp_pkg::KIND_INDY: begin
              res.value_a = {48'd0, acc_sh[31:16]};
              res.value_b = acc_sh[15:0];
            end
            ccp_pkg::KIND_HANDLE: begin
              res.value_a = {56'd0, acc_sh[23:16]};
              res.value_b = acc_sh[15:0];
            end
            default: begin
              res.value_a = acc_sh;
            end
          endcase
          // Long and double take two index slots
          if (e_kind == ccp_pkg::KIND_LONG || e_kind == ccp_pkg::KIND_DOUBLE) begin
            res.is_last_entry = last2;
            cur_index_next    = sum2[15:0];
            phase_next        = last2 ? ccp_pkg::PH_DONE : ccp_pkg::PH_TAG;
          end else begin
            res.is_last_entry = last1;
            cur_index_next    = sum1[15:0];
            phase_next        = last1 ? ccp_pkg::PH_DONE : ccp_pkg::PH_TAG;
          end
          acc_next        = '0;
          bytes_left_next = '0;
        end
      end

      ccp_pkg::PH_ULEN: begin
        acc_next        = acc_sh;
        bytes_left_next = left_dec;
        if (left_dec == 16'd0) begin
          len_hold_next  = acc_sh[15:0];
          res_valid      = 1'b1;
          res.entry_kind = ccp_pkg::KIND_UTF8;
          res.value_a    = {48'd0, acc_sh[15:0]};
          acc_next       = '0;
          if (acc_sh[15:0] == 16'd0) begin
            // Empty string completes on its length
            res.is_last_entry = last1;
            cur_index_next    = sum1[15:0];
            phase_next        = last1 ? ccp_pkg::PH_DONE : ccp_pkg::PH_TAG;
            bytes_left_next   = '0;
          end else begin
            phase_next      = ccp_pkg::PH_UTEXT;
            bytes_left_next = acc_sh[15:0];
          end
        end
      end

      ccp_pkg::PH_UTEXT: begin
        bytes_left_next  = left_dec;
        res_valid        = 1'b1;
        res.entry_kind   = ccp_pkg::KIND_UTF8;
        res.value_a      = {48'd0, e_hold};
        res.text_byte    = byte_value;
        res.is_text_byte = 1'b1;
        if (left_dec == 16'd0) begin
          res.is_last_entry = last1;
          cur_index_next    = sum1[15:0];
          phase_next        = last1 ? ccp_pkg::PH_DONE : ccp_pkg::PH_TAG;
          acc_next          = '0;
          bytes_left_next   = '0;
        end
      end

      default: begin
        // Idle or done: the byte is dropped
        res_valid = 1'b0;
      end
    endcase
  end

  // Pool count register
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_count <= '0;
    end else if (cfg_wr_en) begin
      pool_count <= cfg_wr_data;
    end
  end

  // State update on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= ccp_pkg::PH_IDLE;
      cur_index  <= 16'd1;
      cur_kind   <= ccp_pkg::KIND_UTF8;
      bytes_left <= '0;
      acc        <= '0;
      len_hold   <= '0;
    end else if (step) begin
      phase      <= phase_next;
      cur_index  <= cur_index_next;
      cur_kind   <= cur_kind_next;
      bytes_left <= bytes_left_next;
      acc        <= acc_next;
      len_hold   <= len_hold_next;
    end
  end

endmodule

### sv/ccp_out_reg.sv
// ----------------------------------------------------------------------------
// ccp_out_reg: result holding register
// Keeps one finished result until the downstream side takes it, and tells
// the upstream side when a new result may be loaded.
// ----------------------------------------------------------------------------
module ccp_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_en,
  input  logic             load_valid,
  input  ccp_pkg::result_t load_data,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output ccp_pkg::result_t out_data
);

  // The register can be loaded when empty or being emptied this cycle
  assign space = !out_valid || out_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (space) begin
      out_valid <= load_en && load_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load_en && load_valid) begin
      out_data <= load_data;
    end
  end

endmodule

### sv/class_constant_pool_parser.sv
// ----------------------------------------------------------------------------
// class_constant_pool_parser: class file constant pool parser
// Parses constant pool bytes into one result per entry or utf8 text byte.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle and sustains one byte every cycle: each
// byte passes through a single step of combinational parse logic into the
// result register, and the next byte is taken while a result still waits to
// be read, as long as that register is being emptied. The pool count must be
// written before the beat that carries start_of_pool. A beat with tuser set
// restarts parsing at index 1 with its byte as a tag; at a pool count of 0 or
// 1 it drops the byte. Long and double entries advance the index by two. After
// the entry marked with tlast, bytes are dropped until the next start beat.
module class_constant_pool_parser (
  input  logic         clk,
  input  logic         rst,
  // Pool count register
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,
  // Byte input
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] byte_value
  input  logic         s_axis_tuser,   // [0] start_of_pool
  // Result output
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata,   // [15:0] entry_index, [19:16] entry_kind,
                                       // [83:20] value_a, [99:84] value_b,
                                       // [107:100] text_byte, rest zero
  output logic         m_axis_tuser,   // [0] is_text_byte
  output logic         m_axis_tlast    // is_last_entry
);

  logic             step;
  logic             res_valid;
  ccp_pkg::result_t res;
  logic             space;
  ccp_pkg::result_t out_res;

  // A beat is taken whenever the result register can hold what it makes
  assign s_axis_tready = space;
  assign step          = s_axis_tvalid && s_axis_tready;

  ccp_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .step          (step),
    .byte_value    (s_axis_tdata),
    .start_of_pool (s_axis_tuser),
    .res_valid     (res_valid),
    .res           (res)
  );

  ccp_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load_en    (step),
    .load_valid (res_valid),
    .load_data  (res),
    .space      (space),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (out_res)
  );

  // Pack the result beat
  assign m_axis_tdata = {4'd0, out_res.text_byte, out_res.value_b, out_res.value_a,
                         out_res.entry_kind, out_res.entry_index};
  assign m_axis_tuser = out_res.is_text_byte;
  assign m_axis_tlast = out_res.is_last_entry;

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for class_constant_pool_parser
// Drives constant pool bytes with random gaps and back-pressure, predicts each
// entry result in parallel and compares every result beat field by field. A
// short directed table covers the corner cases, then random pools follow.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned RANDOM_BEATS = 750;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 4;

  // One row of the directed table: a byte beat or a pool count write
  typedef struct {
    bit               is_cfg;
    logic [15:0]      count;
    logic [7:0]       data;
    logic             sop;
    bit               typed;
    ccp_pkg::result_t exp;
  } script_row_t;

  // Per accepted byte: a hand-written expectation, if the row carries one
  typedef struct {
    bit               typed;
    ccp_pkg::result_t exp;
  } beat_note_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_wr_en = 1'b0;
  logic [15:0]  cfg_wr_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;   // [7:0] byte_value
  logic         s_axis_tuser = 1'b0; // [0] start_of_pool
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;        // [15:0] entry_index, [19:16] entry_kind,
                                     // [83:20] value_a, [99:84] value_b,
                                     // [107:100] text_byte
  logic         m_axis_tuser;        // [0] is_text_byte
  logic         m_axis_tlast;

  // Predicted parser state
  logic [15:0]     pool_count = '0;
  ccp_pkg::phase_t parse_phase = ccp_pkg::PH_IDLE;
  logic [15:0]     cur_index = 16'd1;
  logic [3:0]      cur_kind = '0;
  logic [15:0]     bytes_left = '0;
  logic [63:0]     accum = '0;
  logic [15:0]     utf8_len = '0;

  ccp_pkg::result_t expected_entries[$];
  beat_note_t       beat_notes[$];
  script_row_t      script[$];
  int unsigned      mismatches = 0;
  int unsigned      parsed_beats = 0;
  int unsigned      quiet_cycles = 0;
  bit               steady = 1'b0;

  logic [7:0] known_tags [14] = '{ccp_pkg::TAG_UTF8, ccp_pkg::TAG_INTEGER,
                                  ccp_pkg::TAG_FLOAT, ccp_pkg::TAG_LONG,
                                  ccp_pkg::TAG_DOUBLE, ccp_pkg::TAG_CLASS,
                                  ccp_pkg::TAG_STRING, ccp_pkg::TAG_FIELDREF,
                                  ccp_pkg::TAG_METHODREF, ccp_pkg::TAG_IFMETHODREF,
                                  ccp_pkg::TAG_NAMETYPE, ccp_pkg::TAG_HANDLE,
                                  ccp_pkg::TAG_MTYPE, ccp_pkg::TAG_INDY};
  logic [7:0] odd_tags [5] = '{8'd0, 8'd2, 8'd13, 8'd14, 8'd17};

  class_constant_pool_parser u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Entry kind and payload length for a tag byte
  function automatic void tag_layout(input logic [7:0] tag, output logic [3:0] kind,
                                     output int unsigned len);
    case (tag)
      ccp_pkg::TAG_UTF8:        begin kind = ccp_pkg::KIND_UTF8;        len = 2; end
      ccp_pkg::TAG_INTEGER:     begin kind = ccp_pkg::KIND_INT;         len = 4; end
      ccp_pkg::TAG_FLOAT:       begin kind = ccp_pkg::KIND_FLOAT;       len = 4; end
      ccp_pkg::TAG_LONG:        begin kind = ccp_pkg::KIND_LONG;        len = 8; end
      ccp_pkg::TAG_DOUBLE:      begin kind = ccp_pkg::KIND_DOUBLE;      len = 8; end
      ccp_pkg::TAG_CLASS:       begin kind = ccp_pkg::KIND_CLASS;       len = 2; end
      ccp_pkg::TAG_STRING:      begin kind = ccp_pkg::KIND_STRING;      len = 2; end
      ccp_pkg::TAG_FIELDREF:    begin kind = ccp_pkg::KIND_FIELDREF;    len = 4; end
      ccp_pkg::TAG_METHODREF:   begin kind = ccp_pkg::KIND_METHODREF;   len = 4; end
      ccp_pkg::TAG_IFMETHODREF: begin kind = ccp_pkg::KIND_IFMETHODREF; len = 4; end
      ccp_pkg::TAG_NAMETYPE:    begin kind = ccp_pkg::KIND_NAMETYPE;    len = 4; end
      ccp_pkg::TAG_HANDLE:      begin kind = ccp_pkg::KIND_HANDLE;      len = 3; end
      ccp_pkg::TAG_MTYPE:       begin kind = ccp_pkg::KIND_MTYPE;       len = 2; end
      ccp_pkg::TAG_INDY:        begin kind = ccp_pkg::KIND_INDY;        len = 4; end
      default:                  begin kind = ccp_pkg::KIND_UNKNOWN;     len = 0; end
    endcase
  endfunction

  // Closes the current entry; returns whether it was the last of the pool
  function automatic bit complete_entry(input int unsigned slots);
    logic [16:0] next_index;
    bit          last;
    next_index = {1'b0, cur_index} + 17'(slots);
    last = (next_index >= {1'b0, pool_count});
    cur_index = next_index[15:0];
    parse_phase = last ? ccp_pkg::PH_DONE : ccp_pkg::PH_TAG;
    accum = '0;
    bytes_left = '0;
    return last;
  endfunction

  // Advances the predicted parser by one byte; returns 1 when a result is due
  function automatic bit parse_byte(input logic [7:0] d, input logic sop,
                                    output ccp_pkg::result_t r);
    logic [3:0]  kind;
    int unsigned len;
    r = '0;
    if (sop) begin
      cur_index = 16'd1;
      accum = '0;
      bytes_left = '0;
      utf8_len = '0;
      cur_kind = '0;
      if (pool_count <= 16'd1) begin
        parse_phase = ccp_pkg::PH_DONE;
        return 1'b0;
      end
      parse_phase = ccp_pkg::PH_TAG;
    end
    case (parse_phase)
      ccp_pkg::PH_TAG: begin
        tag_layout(d, kind, len);
        accum = '0;
        if (kind == ccp_pkg::KIND_UNKNOWN) begin
          r.entry_index = cur_index;
          r.entry_kind = ccp_pkg::KIND_UNKNOWN;
          r.value_a = {56'd0, d};
          r.is_last_entry = complete_entry(1);
          return 1'b1;
        end
        cur_kind = kind;
        bytes_left = 16'(len);
        parse_phase = (kind == ccp_pkg::KIND_UTF8) ? ccp_pkg::PH_ULEN : ccp_pkg::PH_FIXED;
        return 1'b0;
      end
      ccp_pkg::PH_FIXED: begin
        accum = {accum[55:0], d};
        if (bytes_left != 0) bytes_left--;
        if (bytes_left != 0) return 1'b0;
        r.entry_index = cur_index;
        r.entry_kind = cur_kind;
        case (cur_kind)
          ccp_pkg::KIND_FIELDREF, ccp_pkg::KIND_METHODREF,
          ccp_pkg::KIND_IFMETHODREF, ccp_pkg::KIND_NAMETYPE,
          ccp_pkg::KIND_INDY: begin
            r.value_a = {48'd0, accum[31:16]};
            r.value_b = accum[15:0];
          end
          ccp_pkg::KIND_HANDLE: begin
            r.value_a = {56'd0, accum[23:16]};
            r.value_b = accum[15:0];
          end
          default: r.value_a = accum;
        endcase
        // Long and double occupy two index slots
        r.is_last_entry = complete_entry((cur_kind == ccp_pkg::KIND_LONG ||
                                          cur_kind == ccp_pkg::KIND_DOUBLE) ? 2 : 1);
        return 1'b1;
      end
      ccp_pkg::PH_ULEN: begin
        accum = {accum[55:0], d};
        if (bytes_left != 0) bytes_left--;
        if (bytes_left != 0) return 1'b0;
        utf8_len = accum[15:0];
        r.entry_index = cur_index;
        r.entry_kind = ccp_pkg::KIND_UTF8;
        r.value_a = {48'd0, utf8_len};
        // An empty string finishes on its length beat
        if (utf8_len == 0) begin
          r.is_last_entry = complete_entry(1);
        end else begin
          parse_phase = ccp_pkg::PH_UTEXT;
          bytes_left = utf8_len;
          accum = '0;
        end
        return 1'b1;
      end
      ccp_pkg::PH_UTEXT: begin
        if (bytes_left != 0) bytes_left--;
        r.entry_index = cur_index;
        r.entry_kind = ccp_pkg::KIND_UTF8;
        r.value_a = {48'd0, utf8_len};
        r.text_byte = d;
        r.is_text_byte = 1'b1;
        if (bytes_left == 0) r.is_last_entry = complete_entry(1);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Constructors for the directed table
  function automatic ccp_pkg::result_t entry(input logic [15:0] idx, input logic [3:0] kind,
                                             input logic [63:0] a, input logic [15:0] b,
                                             input logic last);
    ccp_pkg::result_t r;
    r = '0;
    r.entry_index = idx;
    r.entry_kind = kind;
    r.value_a = a;
    r.value_b = b;
    r.is_last_entry = last;
    return r;
  endfunction

  function automatic script_row_t beat(input logic [7:0] d, input logic sop);
    return '{is_cfg: 1'b0, count: '0, data: d, sop: sop, typed: 1'b0, exp: '0};
  endfunction

  function automatic script_row_t beat_exp(input logic [7:0] d, input logic sop,
                                           input ccp_pkg::result_t e);
    return '{is_cfg: 1'b0, count: '0, data: d, sop: sop, typed: 1'b1, exp: e};
  endfunction

  function automatic script_row_t count_row(input logic [15:0] v);
    return '{is_cfg: 1'b1, count: v, data: '0, sop: 1'b0, typed: 1'b0, exp: '0};
  endfunction

  // Presents one byte beat after a random gap and holds it until accepted
  task automatic send_beat(input logic [7:0] d, input logic sop, input bit typed,
                           input ccp_pkg::result_t e);
    while (!steady && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    beat_notes.push_back('{typed: typed, exp: e});
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    s_axis_tuser <= sop;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Stops the byte stream and waits until every predicted result has come out
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_entries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // One well-formed entry with random content, with the odd stray restart
  task automatic send_entry(input logic sop);
    logic [7:0]  tag;
    logic [3:0]  kind;
    int unsigned len;
    int unsigned pick;
    logic [15:0] text_len;
    if ($urandom_range(9) == 0)
      tag = $urandom_range(1) ? odd_tags[$urandom_range(4)] : 8'($urandom_range(255, 19));
    else
      tag = known_tags[$urandom_range(13)];
    tag_layout(tag, kind, len);
    send_beat(tag, sop, 1'b0, '0);
    if (kind == ccp_pkg::KIND_UTF8) begin
      pick = $urandom_range(99);
      if (pick < 10) text_len = '0;
      else if (pick < 98) text_len = 16'($urandom_range(8, 1));
      else text_len = 16'($urandom_range(300, 256));
      send_beat(text_len[15:8], 1'b0, 1'b0, '0);
      send_beat(text_len[7:0], 1'b0, 1'b0, '0);
      repeat (text_len)
        send_beat(8'($urandom_range(255)), $urandom_range(99) < 2, 1'b0, '0);
    end else begin
      repeat (len)
        send_beat(8'($urandom_range(255)), $urandom_range(99) < 2, 1'b0, '0);
    end
  endtask

  // Result sink back-pressure
  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 33);
  end

  // Prediction on accepted bytes and checking of accepted results
  always @(posedge clk) begin
    beat_note_t       note;
    ccp_pkg::result_t predicted;
    ccp_pkg::result_t actual;
    ccp_pkg::result_t want;
    bit               due;
    if (!rst) begin
      if (cfg_wr_en) pool_count = cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready) begin
        note = beat_notes.pop_front();
        if (s_axis_tuser || (parse_phase != ccp_pkg::PH_IDLE &&
                             parse_phase != ccp_pkg::PH_DONE))
          parsed_beats++;
        due = parse_byte(s_axis_tdata, s_axis_tuser, predicted);
        if (note.typed) expected_entries.push_back(note.exp);
        else if (due) expected_entries.push_back(predicted);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        actual.entry_index = m_axis_tdata[15:0];
        actual.entry_kind = m_axis_tdata[19:16];
        actual.value_a = m_axis_tdata[83:20];
        actual.value_b = m_axis_tdata[99:84];
        actual.text_byte = m_axis_tdata[107:100];
        actual.is_text_byte = m_axis_tuser;
        actual.is_last_entry = m_axis_tlast;
        if (expected_entries.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result beat: index %0d kind %0d a %h b %h",
                     actual.entry_index, actual.entry_kind, actual.value_a, actual.value_b);
        end else begin
          want = expected_entries.pop_front();
          if (actual.entry_index !== want.entry_index ||
              actual.entry_kind !== want.entry_kind ||
              actual.value_a !== want.value_a ||
              actual.value_b !== want.value_b ||
              actual.text_byte !== want.text_byte ||
              actual.is_text_byte !== want.is_text_byte ||
              actual.is_last_entry !== want.is_last_entry) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch: expected index %0d kind %0d a %h b %h text %h/%b last %b",
                       want.entry_index, want.entry_kind, want.value_a, want.value_b,
                       want.text_byte, want.is_text_byte, want.is_last_entry);
              $display("          actual   index %0d kind %0d a %h b %h text %h/%b last %b",
                       actual.entry_index, actual.entry_kind, actual.value_a,
                       actual.value_b, actual.text_byte, actual.is_text_byte,
                       actual.is_last_entry);
            end
          end
        end
      end
    end
  end

  // Watchdog: ends the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || cfg_wr_en || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("class_constant_pool_parser verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned pools;
    int unsigned entries;
    int unsigned pick;
    logic [15:0] count;

    // Directed part: idle bytes, empty pool, unknown tags, empty string,
    // restart in the middle of an entry, and a long overshooting the count
    script.push_back(count_row(16'd0));
    script.push_back(beat(ccp_pkg::TAG_UTF8, 1'b0));
    script.push_back(beat(ccp_pkg::TAG_CLASS, 1'b1));
    script.push_back(beat(ccp_pkg::TAG_CLASS, 1'b0));
    script.push_back(count_row(16'hFFFF));
    script.push_back(beat_exp(8'h00, 1'b1,
                              entry(16'd1, ccp_pkg::KIND_UNKNOWN, 64'h0, 16'h0, 1'b0)));
    script.push_back(beat_exp(8'hFF, 1'b0,
                              entry(16'd2, ccp_pkg::KIND_UNKNOWN, 64'hFF, 16'h0, 1'b0)));
    script.push_back(beat(ccp_pkg::TAG_UTF8, 1'b0));
    script.push_back(beat(8'h00, 1'b0));
    script.push_back(beat_exp(8'h00, 1'b0,
                              entry(16'd3, ccp_pkg::KIND_UTF8, 64'h0, 16'h0, 1'b0)));
    script.push_back(beat(ccp_pkg::TAG_METHODREF, 1'b0));
    script.push_back(beat(8'h12, 1'b0));
    script.push_back(beat(8'h34, 1'b0));
    script.push_back(beat(ccp_pkg::TAG_HANDLE, 1'b1));
    script.push_back(beat(8'h09, 1'b0));
    script.push_back(beat(8'hFF, 1'b0));
    script.push_back(beat_exp(8'hFF, 1'b0,
                              entry(16'd1, ccp_pkg::KIND_HANDLE, 64'h9, 16'hFFFF, 1'b0)));
    script.push_back(count_row(16'd2));
    script.push_back(beat(ccp_pkg::TAG_LONG, 1'b1));
    repeat (7) script.push_back(beat(8'hFF, 1'b0));
    script.push_back(beat_exp(8'hFF, 1'b0,
                              entry(16'd1, ccp_pkg::KIND_LONG, '1, 16'h0, 1'b1)));
    script.push_back(beat(8'h2A, 1'b0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        settle();
        write_count(script[i].count);
      end else begin
        send_beat(script[i].data, script[i].sop, script[i].typed, script[i].exp);
      end
    end

    // Random pools; a run of them goes without any gaps or stalls
    pools = 0;
    while (parsed_beats < RANDOM_BEATS) begin
      steady = (pools >= 8 && pools < 14);
      pick = $urandom_range(99);
      if (pick < 5) count = 16'd0;
      else if (pick < 10) count = 16'd1;
      else if (pick < 15) count = 16'hFFFF;
      else if (pick < 20) count = 16'd2;
      else count = 16'($urandom_range(14, 3));
      settle();
      write_count(count);
      // A stray byte before the start beat; it is dropped only if the last pool has ended
      if ($urandom_range(3) == 0) send_beat(8'($urandom_range(255)), 1'b0, 1'b0, '0);
      entries = (count > 1) ? ((count - 1 > 12) ? 12 : count - 1) + $urandom_range(1) : 1;
      for (int unsigned e = 0; e < entries; e++) begin
        // Occasionally change the count while the pool is part parsed
        if (e > 0 && $urandom_range(99) < 8) begin
          settle();
          write_count(16'($urandom_range(12, 1)));
        end
        send_entry(e == 0);
      end
      pools++;
    end
    steady = 1'b0;

    settle();
    if (mismatches == 0 && expected_entries.size() == 0)
      $display("class_constant_pool_parser verification clean");
    else
      $display("class_constant_pool_parser verification failed");
    $finish;
  end

endmodule
